// ----- sv/opsc_pkg.sv -----
// package for the odd-only prime sieve counter
// field widths, default bitmap depth and the sequencer state type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package opsc_pkg;

	localparam int unsigned ODD_SLOTS_DEF = 32768;
	localparam int unsigned LIMIT_W       = 17;
	localparam int unsigned COUNT_W       = 13;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_SQUARE,
		ST_TEST,
		ST_MARK,
		ST_COUNT,
		ST_DONE
	} opsc_state_t;

endpackage

`default_nettype wire

// ----- sv/odd_only_prime_sieve_counter_unit.sv -----
// odd-only prime sieve counter: top level with sequencer, bitmap and result register
// depends on opsc_pkg
//
//  channel   direction  handshake              payload
//  request   in         in_valid / in_stall    limit        (17 bits, unsigned)
//  result    out        out_valid / out_stall  prime_count  (13 bits, unsigned)
//
// one request at a time; in_stall is high from acceptance until the result is
// loaded into the output register. with s = (min(limit, 2*ODD_SLOTS+1) - 1) / 2
// bitmap slots a request clears the s slots, scans them for primes, squares each
// prime found and tests it against the limit, marks its odd multiples from the
// square up, then counts the unmarked slots; marked multiples come to about 1.4*s
// at the top limit. every phase goes through the bitmap one slot at a time.
// limits below 3 skip the sieve and go straight to the done state. arst_n clears
// the sequencer and the result valid; the bitmap slots a request uses are swept
// clear at the start of every request of 3 and up.
// a result held by out_stall does not block the next request; the new result
// waits in the done state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module odd_only_prime_sieve_counter_unit #(
	parameter int unsigned ODD_SLOTS = opsc_pkg::ODD_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [opsc_pkg::LIMIT_W-1:0]  limit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [opsc_pkg::COUNT_W-1:0]  prime_count
);

	import opsc_pkg::*;

	// bitmap address, slot index (holds the slot count itself), multiple index
	localparam int unsigned AW    = $clog2(ODD_SLOTS);
	localparam int unsigned IW    = AW + 1;
	localparam int unsigned JW    = ((IW > LIMIT_W) ? IW : LIMIT_W) + 1;
	localparam int unsigned SQ_W  = 2 * LIMIT_W;
	// largest value the bitmap covers
	localparam int unsigned MAX_N = 2 * ODD_SLOTS + 1;

	opsc_state_t state_q, state_d;

	logic [LIMIT_W-1:0] n_q;
	logic [IW-1:0]      slots_q;
	logic [IW-1:0]      i_q;
	logic [JW-1:0]      j_q;
	logic [LIMIT_W-1:0] q_q;
	logic [SQ_W-1:0]    sq_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               rd_q;
	logic               rd_vld_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] prime_count_q;

	// composite marks, slot k stands for 2*k+3
	logic comp_map [ODD_SLOTS];

	logic          mem_we;
	logic          mem_wdata;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic          load_out;
	logic          accept;

	// request decode
	logic [LIMIT_W-1:0] n_cl;
	logic [LIMIT_W-1:0] n_m1;
	logic [IW-1:0]      slots_d;
	logic               i_in_range;
	logic               j_in_range;
	logic [LIMIT_W-1:0] q_nx;
	logic [SQ_W-1:0]    sq_m3;

	assign n_cl    = (32'(limit) > MAX_N) ? LIMIT_W'(MAX_N) : limit;
	assign n_m1    = n_cl - LIMIT_W'(1);
	assign slots_d = IW'(n_m1[LIMIT_W-1:1]);

	assign i_in_range = (i_q < slots_q);
	assign j_in_range = (j_q < JW'(slots_q));
	assign q_nx       = LIMIT_W'({i_q, 1'b0}) + LIMIT_W'(3);
	assign sq_m3      = sq_q - SQ_W'(3);

	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (limit < LIMIT_W'(3))
						state_d = ST_DONE;
					else
						state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (!i_in_range)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (i_in_range)
					state_d = ST_SCAN_CHK;
				else
					state_d = ST_COUNT;
			end
			ST_SCAN_CHK: begin
				if (rd_q)
					state_d = ST_SCAN;
				else
					state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_TEST;
			ST_TEST: begin
				// prime squared past the limit ends the sieve
				if (sq_q > SQ_W'(n_q))
					state_d = ST_COUNT;
				else
					state_d = ST_MARK;
			end
			ST_MARK: begin
				if (!j_in_range)
					state_d = ST_SCAN;
			end
			ST_COUNT: begin
				if (!i_in_range && !rd_vld_q)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_raddr = i_q[AW-1:0];
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_CLEAR: begin
				mem_we = i_in_range;
			end
			ST_MARK: begin
				mem_we    = j_in_range;
				mem_wdata = 1'b1;
				mem_waddr = j_q[AW-1:0];
			end
			ST_DONE: load_out = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	// bitmap, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			comp_map[mem_waddr] <= mem_wdata;
		rd_q <= comp_map[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rd_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			// count read in flight
			rd_vld_q <= (state_q == ST_COUNT) && i_in_range;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load_out)
			prime_count_q <= cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q     <= n_cl;
					slots_q <= slots_d;
					i_q     <= '0;
					// count starts at zero below 2, else at one for the prime 2, which is all there is at 2
					if (limit < LIMIT_W'(2))
						cnt_q <= '0;
					else
						cnt_q <= COUNT_W'(1);
				end
			end
			ST_CLEAR: begin
				if (i_in_range)
					i_q <= i_q + IW'(1);
				else
					i_q <= '0;
			end
			ST_SCAN: begin
				if (!i_in_range)
					i_q <= '0;
			end
			ST_SCAN_CHK: begin
				if (rd_q)
					i_q <= i_q + IW'(1);
				else
					q_q <= q_nx;
			end
			ST_SQUARE: sq_q <= SQ_W'(q_q) * SQ_W'(q_q);
			ST_TEST: begin
				if (sq_q > SQ_W'(n_q))
					i_q <= '0;
				else
					j_q <= JW'(sq_m3[LIMIT_W:1]);
			end
			ST_MARK: begin
				if (j_in_range)
					j_q <= j_q + JW'(q_q);
				else
					i_q <= i_q + IW'(1);
			end
			ST_COUNT: begin
				if (i_in_range)
					i_q <= i_q + IW'(1);
				if (rd_vld_q && !rd_q)
					cnt_q <= cnt_q + COUNT_W'(1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign prime_count = prime_count_q;

endmodule

`default_nettype wire

// ----- sv/opsc_checker.sv -----
// port-level checks for the odd-only prime sieve counter, bound to the top level
// depends on opsc_pkg and odd_only_prime_sieve_counter_unit
`timescale 1ns / 1ps
`default_nettype none

module opsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [opsc_pkg::LIMIT_W-1:0]  limit,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [opsc_pkg::COUNT_W-1:0]  prime_count
);

	import opsc_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prime_count))
		else $error("result changed or dropped while stalled");

	// busy after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while a run is starting");

	// ready again only with a result in the output register
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("ready again without a result");

	// limits below 2 give no prime
	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && limit < LIMIT_W'(2)
		|=> ##1 out_valid && prime_count == '0)
		else $error("wrong result for a limit below 2");

	// a limit of 2 gives exactly one prime
	a_two_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && limit == LIMIT_W'(2)
		|=> ##1 out_valid && prime_count == COUNT_W'(1))
		else $error("wrong result for a limit of 2");

endmodule

bind odd_only_prime_sieve_counter_unit opsc_checker u_opsc_checker (.*);

`default_nettype wire

// ----- verif/odd_only_prime_sieve_counter_unit_tb.sv -----
// self-checking testbench for the odd-only prime sieve counter unit
// predicts prime counts with its own odd-only sieve and checks them in order; depends on opsc_pkg
`timescale 1ns / 1ps

module odd_only_prime_sieve_counter_unit_tb;
	import opsc_pkg::*;

	// random requests after the directed part
	localparam int unsigned RANDOM_REQS  = 100;
	// random index at which the result side starts its long hold-off
	localparam int unsigned HOLD_AT      = 40;
	localparam int unsigned HOLD_CYCLES  = 5000;
	// random index before which the request side waits for every result
	localparam int unsigned DRAIN_AT     = 70;
	// random requests allowed over the whole limit range
	localparam int unsigned WIDE_REQS    = 2;
	// watchdog bound on the whole run, even with heavy output stall
	localparam int unsigned CYCLE_LIMIT  = 4000000;
	// quiet cycles after the last result
	localparam int unsigned TAIL_CYCLES  = 50;

	// result-side stall patterns
	localparam int unsigned STALL_NONE   = 0;
	localparam int unsigned STALL_LIGHT  = 1;
	localparam int unsigned STALL_HEAVY  = 2;
	localparam int unsigned STALL_TOGGLE = 3;

	typedef struct {
		logic [LIMIT_W-1:0] limit;
		logic [COUNT_W-1:0] count;
	} count_expect_t;

	// holds expected prime counts in request order and checks results against them
	class prime_count_tracker;
		bit            odd_composite [ODD_SLOTS_DEF];
		count_expect_t pending_counts [$];
		int unsigned   mismatches;

		function new();
			mismatches = 0;
		endfunction

		// number of primes <= n, sieving odd values 3, 5, 7, ... only
		function logic [COUNT_W-1:0] count_primes_upto(logic [LIMIT_W-1:0] n_in);
			longint unsigned n, top, slots, q, j, tally;
			n = 64'(n_in);
			top = 2 * longint'(ODD_SLOTS_DEF) + 1;
			if (n < 2) begin
				return '0;
			end
			if (n == 2) begin
				return COUNT_W'(1);
			end
			if (n > top) begin
				n = top;
			end
			// slot i stands for 2*i+3
			slots = (n - 3) / 2 + 1;
			for (longint unsigned i = 0; i < slots; i++) begin
				odd_composite[i] = 1'b0;
			end
			for (longint unsigned i = 0; i < slots; i++) begin
				if (odd_composite[i]) begin
					continue;
				end
				q = 2 * i + 3;
				if (q * q > n) begin
					break;
				end
				for (j = (q * q - 3) / 2; j < slots; j += q) begin
					odd_composite[j] = 1'b1;
				end
			end
			tally = 1;
			for (longint unsigned i = 0; i < slots; i++) begin
				if (!odd_composite[i]) begin
					tally++;
				end
			end
			return tally[COUNT_W-1:0];
		endfunction

		function void note_limit(logic [LIMIT_W-1:0] n);
			count_expect_t e;
			e.limit = n;
			e.count = count_primes_upto(n);
			pending_counts.push_back(e);
		endfunction

		function void check_count(logic [COUNT_W-1:0] got);
			count_expect_t e;
			if (pending_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with no request pending: prime_count=%0d", got);
				end
				return;
			end
			e = pending_counts.pop_front();
			if (got !== e.count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("limit=%0d: prime_count expected %0d, got %0d", e.limit, e.count, got);
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending_counts.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [LIMIT_W-1:0] limit = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COUNT_W-1:0] prime_count;

	prime_count_tracker tracker = new();

	// set by the request side once, read by the result side to start the long hold-off
	bit          hold_armed = 1'b0;
	int unsigned cycle_cnt = 0;

	// directed limits: tiny limits, squares of primes and their neighbors,
	// exact top of the bitmap, and the all-ones limit that gets clamped
	int unsigned directed_limits [$] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 10, 17, 24, 25, 26,
		48, 49, 50, 120, 121, 122, 1000, 9409, 65537, 131071};

	odd_only_prime_sieve_counter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.limit       (limit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prime_count (prime_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// offer one request and return at the edge where it is taken;
	// in_valid stays high so a back-to-back request needs no extra edge
	task automatic send_limit(input logic [LIMIT_W-1:0] n);
		limit <= n;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		tracker.note_limit(n);
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (tracker.outstanding() != 0);
	endtask

	// random limit: mostly small runs, some mid-size, a couple over the full range
	function automatic logic [LIMIT_W-1:0] pick_limit(inout int unsigned wide_left);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return LIMIT_W'($urandom_range(0, 255));
		end
		if (roll < 85) begin
			return LIMIT_W'($urandom_range(256, 1023));
		end
		if (roll < 97 || wide_left == 0) begin
			return LIMIT_W'($urandom_range(1024, 4095));
		end
		wide_left--;
		return LIMIT_W'($urandom_range(0, 131071));
	endfunction

	// request side
	initial begin : request_side
		int unsigned burst_left;
		int unsigned wide_left;
		logic [LIMIT_W-1:0] n;
		burst_left = $urandom_range(1, 8);
		wide_left = WIDE_REQS;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		foreach (directed_limits[k]) begin
			send_limit(LIMIT_W'(directed_limits[k]));
		end
		drain_results();

		for (int unsigned idx = 0; idx < RANDOM_REQS; idx++) begin
			if (idx == HOLD_AT) begin
				hold_armed = 1'b1;
			end
			// during the hold-off keep requests short and back to back so the
			// unit fills up and has to stall its input
			if (idx >= HOLD_AT && idx < HOLD_AT + 12) begin
				n = LIMIT_W'($urandom_range(0, 200));
			end else begin
				n = pick_limit(wide_left);
			end
			send_limit(n);

			if (idx + 1 == DRAIN_AT) begin
				drain_results();
			end else if (idx >= HOLD_AT && idx < HOLD_AT + 12) begin
				// no gaps while the result side holds off
			end else if (burst_left > 1) begin
				burst_left--;
			end else begin
				// end of burst: idle for a while, then start a new one
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side: take results, check them, drive out_stall
	initial begin : result_side
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          hold_done;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;

		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				tracker.check_count(prime_count);
			end

			// one long hold-off, counted here
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end

			// switch stall pattern now and then
			if (mode_left == 0) begin
				mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end

			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					STALL_LIGHT: begin
						out_stall <= ($urandom_range(0, 3) == 0);
					end
					STALL_HEAVY: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
					STALL_TOGGLE: begin
						out_stall <= ~out_stall;
					end
					default: begin
						out_stall <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule

// ----- filelist.f -----
sv/opsc_pkg.sv
sv/odd_only_prime_sieve_counter_unit.sv
sv/opsc_checker.sv
verif/odd_only_prime_sieve_counter_unit_tb.sv
